// File: rtl/pec_pkg.sv
`default_nettype none

package pec_pkg;

  // Geometry
  localparam int unsigned MaxOutSize = 4096;
  localparam int unsigned CfgW       = 13;
  localparam int unsigned LimitW     = 13;
  localparam int unsigned CountOutW  = 12;
  localparam int unsigned PreLenW    = 3;
  localparam int unsigned QueueDepth = 2;

  // Escape sequence "&pipe;" and the character it stands for
  localparam int unsigned SeqLen   = 6;
  localparam logic [7:0]  PipeChar = 8'h7C;
  localparam logic [7:0]  AmpChar  = 8'h26;
  localparam logic [7:0]  NulChar  = 8'h00;

  // Configuration register indexes
  localparam logic RegMode  = 1'b0;
  localparam logic RegLimit = 1'b1;

  // Modes
  localparam logic ModeEscape   = 1'b0;
  localparam logic ModeUnescape = 1'b1;

  // What follows the flushed prefix in one command
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_BYTE,
    TAIL_SEQ,
    TAIL_END
  } tail_e;

  // One command from the classifier to the writer
  typedef struct packed {
    logic [PreLenW-1:0] pre_len;
    tail_e              tail;
    logic [7:0]         data;
  } cmd_t;

  // Byte of "&pipe;" at a position
  function automatic logic [7:0] seq_byte(input logic [PreLenW-1:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h26;
      3'd1:    b = 8'h70;
      3'd2:    b = 8'h69;
      3'd3:    b = 8'h70;
      3'd4:    b = 8'h65;
      3'd5:    b = 8'h3B;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pec_front.sv
`default_nettype none

module pec_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          mode_i,
  input  wire logic          mode_wr_i,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  output pec_pkg::cmd_t      cmd_o,
  output logic               push_o
);

  localparam logic [pec_pkg::PreLenW-1:0] LastPos =
    pec_pkg::PreLenW'(pec_pkg::SeqLen - 1);

  logic [pec_pkg::PreLenW-1:0] match_q, match_d;
  logic                        need;

  // Classify the incoming word against the running partial match
  always_comb begin
    match_d       = match_q;
    need          = 1'b0;
    cmd_o.pre_len = '0;
    cmd_o.tail    = pec_pkg::TAIL_NONE;
    cmd_o.data    = in_byte_i;
    if (in_byte_i == pec_pkg::NulChar) begin
      // flush pending prefix in unescape mode, then close the string
      need       = 1'b1;
      cmd_o.tail = pec_pkg::TAIL_END;
      if (mode_i == pec_pkg::ModeUnescape) begin
        cmd_o.pre_len = match_q;
      end
      match_d = '0;
    end else if (mode_i == pec_pkg::ModeEscape) begin
      need = 1'b1;
      if (in_byte_i == pec_pkg::PipeChar) begin
        cmd_o.tail = pec_pkg::TAIL_SEQ;
      end else begin
        cmd_o.tail = pec_pkg::TAIL_BYTE;
      end
    end else if (in_byte_i == pec_pkg::seq_byte(match_q)) begin
      // extend the match, emit a pipe once complete
      if (match_q == LastPos) begin
        need       = 1'b1;
        cmd_o.tail = pec_pkg::TAIL_BYTE;
        cmd_o.data = pec_pkg::PipeChar;
        match_d    = '0;
      end else begin
        match_d = match_q + 1'b1;
      end
    end else begin
      // mismatch: write the prefix literally, then restart on this word
      need          = 1'b1;
      cmd_o.pre_len = match_q;
      if (in_byte_i == pec_pkg::AmpChar) begin
        cmd_o.tail = pec_pkg::TAIL_NONE;
        match_d    = pec_pkg::PreLenW'(1);
      end else begin
        cmd_o.tail = pec_pkg::TAIL_BYTE;
        match_d    = '0;
      end
    end
  end

  assign push_o = accept_i & need;

  // Hold the match length; a mode write drops it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else if (mode_wr_i) begin
      match_q <= '0;
    end else if (accept_i) begin
      match_q <= match_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pec_queue.sv
`default_nettype none

module pec_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire pec_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output pec_pkg::cmd_t      head_o,
  output logic               head_valid_o
);

  localparam int unsigned PtrW = $clog2(pec_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(pec_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(pec_pkg::QueueDepth);

  pec_pkg::cmd_t         slot_q [pec_pkg::QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       cnt_q;
  logic                  do_push, do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(pec_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(pec_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pec_back.sv
`default_nettype none

module pec_back #(
  parameter int unsigned MAX_OUT_SIZE = pec_pkg::MaxOutSize
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [pec_pkg::LimitW-1:0]     limit_i,
  input  wire pec_pkg::cmd_t                  head_i,
  input  wire logic                           head_valid_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [7:0]                          out_byte_o,
  output logic                                out_end_o,
  output logic [pec_pkg::CountOutW-1:0]       out_count_o
);

  // Usable limit is capped by the limit register width
  localparam int unsigned LimMax  = (1 << pec_pkg::LimitW) - 1;
  localparam int unsigned MaxLim  = (MAX_OUT_SIZE > LimMax) ? LimMax : MAX_OUT_SIZE;
  localparam int unsigned CntW    = $clog2(MaxLim);
  localparam int unsigned SumW    = pec_pkg::LimitW + 1;
  localparam logic [pec_pkg::LimitW-1:0] MaxLimV = pec_pkg::LimitW'(MaxLim);
  localparam logic [pec_pkg::PreLenW-1:0] LastPos =
    pec_pkg::PreLenW'(pec_pkg::SeqLen - 1);

  logic [CntW-1:0]                count_q, count_d;
  logic                           stop_q, stop_d;
  logic [pec_pkg::PreLenW-1:0]    pos_q, pos_d;
  logic                           out_valid_q, out_valid_d;
  logic [7:0]                     out_byte_q;
  logic                           out_end_q;
  logic [CntW-1:0]                out_cnt_q;
  logic [pec_pkg::LimitW-1:0]     lim;
  logic                           fit1, fit6, step, emit, emit_end;
  logic [7:0]                     emit_data;
  logic [CntW+pec_pkg::CountOutW-1:0] cnt_wide;

  // Effective limit: zero acts as one, large values saturate
  always_comb begin
    if (limit_i == '0) begin
      lim = pec_pkg::LimitW'(1);
    end else if (limit_i > MaxLimV) begin
      lim = MaxLimV;
    end else begin
      lim = limit_i;
    end
  end

  assign fit1 = (SumW'(count_q) + SumW'(1)) < SumW'(lim);
  assign fit6 = (SumW'(count_q) + SumW'(pec_pkg::SeqLen)) < SumW'(lim);
  assign step = head_valid_i & (~out_valid_q | ~out_stall_i);

  // Execute one step of the head command
  always_comb begin
    count_d   = count_q;
    stop_d    = stop_q;
    pos_d     = pos_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_end  = 1'b0;
    emit_data = pec_pkg::seq_byte(pos_q);
    if (step) begin
      pos_d = pos_q + 1'b1;
      if (pos_q < head_i.pre_len) begin
        // literal prefix byte under the fit test
        if (!stop_q && fit1) begin
          emit    = 1'b1;
          count_d = count_q + 1'b1;
        end else begin
          stop_d = 1'b1;
        end
      end else begin
        case (head_i.tail)
          pec_pkg::TAIL_NONE: begin
            pop_o = 1'b1;
          end
          pec_pkg::TAIL_BYTE: begin
            emit_data = head_i.data;
            pop_o     = 1'b1;
            if (!stop_q && fit1) begin
              emit    = 1'b1;
              count_d = count_q + 1'b1;
            end else begin
              stop_d = 1'b1;
            end
          end
          pec_pkg::TAIL_SEQ: begin
            if (pos_q == '0) begin
              // whole sequence fits or nothing of it is written
              if (stop_q || !fit6) begin
                stop_d = 1'b1;
                pop_o  = 1'b1;
              end else begin
                emit    = 1'b1;
                count_d = count_q + CntW'(pec_pkg::SeqLen);
              end
            end else begin
              emit  = 1'b1;
              pop_o = (pos_q == LastPos);
            end
          end
          pec_pkg::TAIL_END: begin
            emit      = 1'b1;
            emit_end  = 1'b1;
            emit_data = pec_pkg::NulChar;
            count_d   = '0;
            stop_d    = 1'b0;
            pop_o     = 1'b1;
          end
          default: begin
            pop_o = 1'b1;
          end
        endcase
      end
      if (pop_o) begin
        pos_d = '0;
      end
    end
  end

  assign out_valid_d = emit | (out_valid_q & out_stall_i);

  // Advance writer state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      stop_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      stop_q      <= stop_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the output word
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_data;
      out_end_q  <= emit_end;
      out_cnt_q  <= emit_end ? count_q : '0;
    end
  end

  assign cnt_wide    = {{pec_pkg::CountOutW{1'b0}}, out_cnt_q};
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_end_o   = out_end_q;
  assign out_count_o = cnt_wide[pec_pkg::CountOutW-1:0];

endmodule

`default_nettype wire

// File: rtl/pipe_escape_codec.sv
// Channel  | Handshake                | Payload
// ---------+--------------------------+-----------------------------------
// in       | in_valid_i / in_stall_o  | in_byte_i
// out      | out_valid_o / out_stall_i| out_byte_o, out_end_o, out_count_o
// cfg      | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One input word per cycle is taken while the two-entry command queue has
// room; the writer drains one command step per cycle while the output is
// not stalled, so an escaped pipe or a flushed prefix can hold the input.
// The first result of a word passes through the command queue and then
// the output register. Reset clears the match, count, stop flag, queue and
// output valid flag; mode resets to escape and the limit to 4096.
`default_nettype none

module pipe_escape_codec #(
  parameter int unsigned MAX_OUT_SIZE = pec_pkg::MaxOutSize
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [7:0]                   in_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [7:0]                        out_byte_o,
  output logic                              out_end_o,
  output logic [pec_pkg::CountOutW-1:0]     out_count_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [pec_pkg::CfgW-1:0]     cfg_wdata_i
);

  logic                         mode_q;
  logic [pec_pkg::LimitW-1:0]   limit_q;
  logic                         mode_wr, accept, push, full, pop, head_valid;
  pec_pkg::cmd_t                cmd, head;

  assign mode_wr    = cfg_we_i & (cfg_idx_i == pec_pkg::RegMode);
  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pec_pkg::ModeEscape;
      limit_q <= pec_pkg::LimitW'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pec_pkg::RegMode:  mode_q  <= cfg_wdata_i[0];
        pec_pkg::RegLimit: limit_q <= cfg_wdata_i[pec_pkg::LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  pec_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .mode_wr_i (mode_wr),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .cmd_o     (cmd),
    .push_o    (push)
  );

  pec_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  pec_back #(
    .MAX_OUT_SIZE (MAX_OUT_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_end_o    (out_end_o),
    .out_count_o  (out_count_o)
  );

endmodule

`default_nettype wire
